// File: rtl/cfis_pkg.sv
// package for the circular free inode search block
// holds field widths, bitmap geometry, the sequencer state type and a priority encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cfis_pkg;

    // bitmap geometry
    localparam int MAX_INODES = 4096;
    localparam int WORD_W     = 64;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WORDS      = (MAX_INODES + WORD_W - 1) / WORD_W;
    localparam int WAW        = (WORDS > 1) ? $clog2(WORDS) : 1;

    // field widths
    localparam int INO_W = 13;
    localparam int CFG_W = 13;
    localparam int IDX_W = 2;
    localparam int CNT_W = $clog2(INO_W + 1);

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_INODE_TOTAL = 2'd0;
    localparam logic [IDX_W-1:0] CFG_PER_GROUP   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_FIRST_INODE = 2'd2;

    // request codes
    localparam logic REQ_MARK = 1'b0;
    localparam logic REQ_FIND = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_START,
        S_SCAN_RD,
        S_SCAN_EV,
        S_MARK_RD,
        S_MARK_WR,
        S_DONE
    } t_state;

    // index of the lowest set bit, zero when none
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] vec);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (vec[k]) begin
                pos = BIT_W'(k);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// File: rtl/circular_free_inode_search.sv
// top level of the circular free inode search block
// usage bitmap memory, remainder divider and word scan sequencer
// depends on cfis_pkg
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                  payload
// cfg       in         i_cfg_we                   i_cfg_idx, i_cfg_data
// in        in         i_in_valid / o_in_stall    i_req_type, i_inode_number, i_parent_dir
// out       out        o_out_valid / i_out_stall  o_found, o_free_inode
//
// a mark beat reads one bitmap word, writes it back with the bit set, then reports
// a find beat may first run the divider for the parent group, then reads and checks
// one 64-bit bitmap word at a time on the read port, until a free bit or a full circle
// reset is synchronous and active low; one valid bit per bitmap word makes the whole
// bitmap read as free right after reset, with no clearing pass
// a new beat is taken while a finished result still waits on a stalled output

module circular_free_inode_search
    import cfis_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_req_type,
    input  wire logic [INO_W-1:0] i_inode_number,
    input  wire logic [INO_W-1:0] i_parent_dir,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic                  o_found,
    output logic [INO_W-1:0]      o_free_inode
);

    localparam logic [INO_W-1:0] MAX_INO = INO_W'(MAX_INODES);

    // configuration registers
    logic [CFG_W-1:0] r_cfg_total;
    logic [CFG_W-1:0] r_cfg_ipg;
    logic [CFG_W-1:0] r_cfg_first;

    // sequencer registers
    t_state           r_state, n_state;
    logic [INO_W-1:0] r_cur, n_cur;
    logic [INO_W-1:0] r_limit, n_limit;
    logic [INO_W-1:0] r_start, n_start;
    logic [INO_W-1:0] r_dir, n_dir;
    logic [INO_W-1:0] r_num, n_num;
    logic [INO_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_phase, n_phase;
    logic             r_res_found, n_res_found;
    logic [INO_W-1:0] r_res_inode, n_res_inode;

    // output register
    logic             r_out_vld, n_out_vld;
    logic             r_out_found, n_out_found;
    logic [INO_W-1:0] r_out_inode, n_out_inode;

    // bitmap memory and per-word valid bits
    logic [WORD_W-1:0] mem [WORDS];
    logic [WORDS-1:0]  r_row_vld;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_vld;

    // derived configuration
    logic [INO_W-1:0] total;
    logic [INO_W-1:0] first;

    // word decode of the current inode
    logic [INO_W-1:0]  cur_b;
    logic [WAW-1:0]    cur_word;
    logic [BIT_W-1:0]  cur_off;
    logic [INO_W-1:0]  lim_b;
    logic [WORD_W-1:0] eff_word;
    logic [WORD_W-1:0] lo_mask;
    logic [WORD_W-1:0] hi_mask;
    logic [WORD_W-1:0] free_bits;
    logic [INO_W-1:0]  next_cur;
    logic [INO_W:0]    div_try;
    logic              wr_en;

    assign total = (r_cfg_total > MAX_INO) ? MAX_INO : r_cfg_total;
    assign first = (r_cfg_first == '0) ? INO_W'(1) : r_cfg_first;

    assign cur_b    = r_cur - INO_W'(1);
    assign cur_word = cur_b[BIT_W+WAW-1:BIT_W];
    assign cur_off  = cur_b[BIT_W-1:0];
    assign lim_b    = r_limit - INO_W'(1);
    assign eff_word = r_rd_vld ? r_rd_data : '0;
    assign lo_mask  = {WORD_W{1'b1}} << cur_off;
    assign hi_mask  = (lim_b[BIT_W+WAW-1:BIT_W] == cur_word)
                    ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - lim_b[BIT_W-1:0]))
                    : {WORD_W{1'b1}};
    assign free_bits = ~eff_word & lo_mask & hi_mask;
    assign next_cur  = INO_W'((INO_W'(cur_word) + INO_W'(1)) << BIT_W) + INO_W'(1);
    assign div_try   = {r_rem, r_num[INO_W-1]};

    assign wr_en = (r_state == S_MARK_WR);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_total <= CFG_W'(4096);
            r_cfg_ipg   <= CFG_W'(2048);
            r_cfg_first <= CFG_W'(11);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INODE_TOTAL: r_cfg_total <= i_cfg_data;
                CFG_PER_GROUP:   r_cfg_ipg   <= i_cfg_data;
                CFG_FIRST_INODE: r_cfg_first <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // bitmap memory, one word read and one word write port
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[cur_word];
        if (wr_en) begin
            mem[cur_word] <= eff_word | (WORD_W'(1) << cur_off);
        end
    end

    // word valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= r_row_vld[cur_word];
            if (wr_en) begin
                r_row_vld[cur_word] <= 1'b1;
            end
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_limit     <= n_limit;
        r_start     <= n_start;
        r_dir       <= n_dir;
        r_num       <= n_num;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_phase     <= n_phase;
        r_res_found <= n_res_found;
        r_res_inode <= n_res_inode;
        r_out_found <= n_out_found;
        r_out_inode <= n_out_inode;
    end

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_limit     = r_limit;
        n_start     = r_start;
        n_dir       = r_dir;
        n_num       = r_num;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_phase     = r_phase;
        n_res_found = r_res_found;
        n_res_inode = r_res_inode;
        n_out_found = r_out_found;
        n_out_inode = r_out_inode;
        n_out_vld   = r_out_vld && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_found = 1'b0;
                    n_res_inode = '0;
                    n_cur       = i_inode_number;
                    n_dir       = i_parent_dir;
                    if (i_req_type == REQ_MARK) begin
                        if (i_inode_number != '0 && i_inode_number <= total) begin
                            n_state = S_MARK_RD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else if (first > total) begin
                        n_state = S_DONE;
                    end else if (i_parent_dir != '0 && r_cfg_ipg != '0) begin
                        n_num   = i_parent_dir - INO_W'(1);
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end else begin
                        n_start = INO_W'(1);
                        n_state = S_START;
                    end
                end
            end

            // restoring divide, one quotient bit a cycle, only the remainder is kept
            S_DIV: begin
                n_num = r_num << 1;
                if (div_try >= {1'b0, r_cfg_ipg}) begin
                    n_rem = INO_W'(div_try - {1'b0, r_cfg_ipg});
                end else begin
                    n_rem = div_try[INO_W-1:0];
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(INO_W - 1)) begin
                    n_start = r_dir - n_rem;
                    n_state = S_START;
                end
            end

            // clamp start into the usable range, first leg runs up to the total
            S_START: begin
                if (r_start < first || r_start > total) begin
                    n_start = first;
                    n_cur   = first;
                end else begin
                    n_cur   = r_start;
                end
                n_limit = total;
                n_phase = 1'b0;
                n_state = S_SCAN_RD;
            end

            S_SCAN_RD: begin
                n_state = S_SCAN_EV;
            end

            // look for a free bit in the window of this word
            S_SCAN_EV: begin
                if (free_bits != '0) begin
                    n_res_found = 1'b1;
                    n_res_inode = INO_W'({cur_word, lowest_set(free_bits)}) + INO_W'(1);
                    n_state     = S_DONE;
                end else if (next_cur > r_limit) begin
                    if (!r_phase && r_start > first) begin
                        n_phase = 1'b1;
                        n_cur   = first;
                        n_limit = r_start - INO_W'(1);
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_cur   = next_cur;
                    n_state = S_SCAN_RD;
                end
            end

            S_MARK_RD: begin
                n_state = S_MARK_WR;
            end

            S_MARK_WR: begin
                n_res_found = 1'b1;
                n_state     = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld   = 1'b1;
                    n_out_found = r_res_found;
                    n_out_inode = r_res_inode;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_vld;
    assign o_found      = r_out_found;
    assign o_free_inode = r_out_inode;

endmodule

`default_nettype wire
